// File: design/sdbs_pkg.sv
// ----------------------------------------------------------------------------
// sdbs_pkg
// Shared types, constants and helpers of the sigma-delta background
// subtraction pipeline.
// ----------------------------------------------------------------------------
package sdbs_pkg;

  localparam int PIXELS    = 262144;
  localparam int IDX_W     = 18;
  localparam int PIX_W     = 8;
  localparam int AMP_W     = 4;
  localparam int ADDR_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_AMP_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_MAX = 2'd2;

  localparam logic [AMP_W-1:0] AMP_FACTOR_RST   = 4'd2;
  localparam logic [PIX_W-1:0] VARIANCE_MIN_RST = 8'd1;
  localparam logic [PIX_W-1:0] VARIANCE_MAX_RST = 8'd254;

  localparam logic FUNC_INIT   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] pixel_index;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic             motion;
    logic [PIX_W-1:0] abs_difference;
  } out_item_t;

  // A write to the pixel stores that is still in flight or was just done.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] mean;
    logic [PIX_W-1:0] var_val;
  } wr_rec_t;

  typedef struct packed {
    logic             valid;
    logic             we;
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
  } s1_t;

  typedef struct packed {
    logic             valid;
    logic             we;
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] mean;
    logic [PIX_W-1:0] diff;
    logic [PIX_W-1:0] var_old;
  } s2_t;

  typedef struct packed {
    logic             valid;
    logic             we;
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] mean;
    logic [PIX_W-1:0] diff;
    logic [PIX_W-1:0] var_val;
  } s3_t;

  function automatic logic [PIX_W-1:0] step_toward(input logic [PIX_W-1:0] cur,
                                                   input logic [PIX_W-1:0] tgt);
    logic [PIX_W-1:0] res;
    res = cur;
    if (cur < tgt) begin
      res = cur + 1'b1;
    end else if (cur > tgt) begin
      res = cur - 1'b1;
    end
    return res;
  endfunction

endpackage

// File: design/sdbs_store.sv
// ----------------------------------------------------------------------------
// sdbs_store
// Per-pixel mean and variance memory, one read and one write port, with
// registered read data that holds while the pipeline is frozen.
// ----------------------------------------------------------------------------
module sdbs_store (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [sdbs_pkg::IDX_W-1:0] rd_idx,
  output logic [sdbs_pkg::PIX_W-1:0] rd_mean,
  output logic [sdbs_pkg::PIX_W-1:0] rd_var,
  input  logic                       wr_en,
  input  logic [sdbs_pkg::IDX_W-1:0] wr_idx,
  input  logic [sdbs_pkg::PIX_W-1:0] wr_mean,
  input  logic [sdbs_pkg::PIX_W-1:0] wr_var
);
  import sdbs_pkg::*;

  logic [2*PIX_W-1:0] mem [0:PIXELS-1];
  logic [2*PIX_W-1:0] rd_data_r;

  // The read sees the contents before a write on the same edge; the
  // pipeline forwards around that.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= mem[rd_idx[ADDR_W-1:0]];
      if (wr_en) begin
        mem[wr_idx[ADDR_W-1:0]] <= {wr_mean, wr_var};
      end
    end
  end

  assign rd_mean = rd_data_r[2*PIX_W-1:PIX_W];
  assign rd_var  = rd_data_r[PIX_W-1:0];

endmodule

// File: design/sdbs_mean_stage.sv
// ----------------------------------------------------------------------------
// sdbs_mean_stage
// Resolves the stored model of the pixel against writes still in flight,
// steps the mean toward the pixel (an init request loads it) and forms the absolute difference.
// ----------------------------------------------------------------------------
module sdbs_mean_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  sdbs_pkg::s1_t              s1_i,
  input  logic [sdbs_pkg::PIX_W-1:0] rd_mean,
  input  logic [sdbs_pkg::PIX_W-1:0] rd_var,
  input  sdbs_pkg::wr_rec_t          fwd_c,
  input  sdbs_pkg::wr_rec_t          fwd_b,
  input  sdbs_pkg::wr_rec_t          fwd_a,
  output sdbs_pkg::s2_t              s2_o
);
  import sdbs_pkg::*;

  s2_t              s2_r;
  s2_t              s2_nxt;
  logic             hit_c;
  logic             hit_b;
  logic             hit_a;
  logic [PIX_W-1:0] mean_cur;
  logic [PIX_W-1:0] var_cur;
  logic [PIX_W-1:0] mean_new;

  assign hit_c = fwd_c.we && (fwd_c.idx == s1_i.idx);
  assign hit_b = fwd_b.we && (fwd_b.idx == s1_i.idx);
  assign hit_a = fwd_a.we && (fwd_a.idx == s1_i.idx);

  always_comb begin
    // The youngest write wins. The variance of the item one stage ahead is
    // not known yet; the next stage checks it.
    priority if (hit_c) begin
      mean_cur = fwd_c.mean;
    end else if (hit_b) begin
      mean_cur = fwd_b.mean;
    end else if (hit_a) begin
      mean_cur = fwd_a.mean;
    end else begin
      mean_cur = rd_mean;
    end
    priority if (hit_b) begin
      var_cur = fwd_b.var_val;
    end else if (hit_a) begin
      var_cur = fwd_a.var_val;
    end else begin
      var_cur = rd_var;
    end
  end

  always_comb begin
    s2_nxt.valid   = s1_i.valid;
    s2_nxt.we      = s1_i.we;
    s2_nxt.func    = s1_i.func;
    s2_nxt.idx     = s1_i.idx;
    s2_nxt.var_old = var_cur;
    mean_new       = step_toward(mean_cur, s1_i.pix);
    if (s1_i.func == FUNC_INIT) begin
      s2_nxt.mean = s1_i.pix;
      s2_nxt.diff = '0;
    end else begin
      s2_nxt.mean = mean_new;
      s2_nxt.diff = (mean_new > s1_i.pix) ? (mean_new - s1_i.pix) : (s1_i.pix - mean_new);
    end
    if (!s1_i.we) begin
      s2_nxt.diff = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_o = s2_r;

endmodule

// File: design/sdbs_var_stage.sv
// ----------------------------------------------------------------------------
// sdbs_var_stage
// Scales the difference by the gain, steps the variance toward it and
// clamps the result to the configured window; an init request loads variance_min.
// ----------------------------------------------------------------------------
module sdbs_var_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  sdbs_pkg::s2_t              s2_i,
  input  sdbs_pkg::wr_rec_t          fwd_d,
  input  logic [sdbs_pkg::AMP_W-1:0] amp_factor,
  input  logic [sdbs_pkg::PIX_W-1:0] variance_min,
  input  logic [sdbs_pkg::PIX_W-1:0] variance_max,
  output sdbs_pkg::s3_t              s3_o
);
  import sdbs_pkg::*;

  localparam int PROD_W = PIX_W + AMP_W;

  s3_t               s3_r;
  s3_t               s3_nxt;
  logic [PIX_W-1:0]  var_cur;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  target;
  logic [PIX_W-1:0]  var_step;
  logic [PIX_W-1:0]  var_hi;
  logic [PIX_W-1:0]  var_clamp;

  assign var_cur = (fwd_d.we && (fwd_d.idx == s2_i.idx)) ? fwd_d.var_val : s2_i.var_old;

  always_comb begin
    prod      = PROD_W'(s2_i.diff) * PROD_W'(amp_factor);
    target    = (prod > PROD_W'(8'hFF)) ? 8'hFF : prod[PIX_W-1:0];
    var_step  = step_toward(var_cur, target);
    var_hi    = (var_step > variance_max) ? variance_max : var_step;
    var_clamp = (var_hi < variance_min) ? variance_min : var_hi;

    s3_nxt.valid   = s2_i.valid;
    s3_nxt.we      = s2_i.we;
    s3_nxt.func    = s2_i.func;
    s3_nxt.idx     = s2_i.idx;
    s3_nxt.mean    = s2_i.mean;
    s3_nxt.diff    = s2_i.diff;
    s3_nxt.var_val = (s2_i.func == FUNC_INIT) ? variance_min : var_clamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3_o = s3_r;

endmodule

// File: design/sigma_delta_background_subtract_top.sv
// ----------------------------------------------------------------------------
// sigma_delta_background_subtract_top
// Per-pixel sigma-delta motion detector with mean and variance stores.
//
// The input channel takes one pixel request per cycle (func, pixel_index,
// pixel_value) on in_valid/in_stall; the result channel returns one result
// per request (motion, abs_difference) on out_valid/out_stall, in order.
// A request accepted into stage one moves through stages two and three to
// the output register; the sustained rate, unless out_stall freezes the
// pipeline, is one pixel per cycle, set by the single read and single write
// port of the memory; same-pixel hazards are forwarded from in-flight stages.
// Reset empties the pipeline and loads amp_factor = 2, variance_min = 1,
// variance_max = 254; stores are not cleared, so each pixel takes an init
// request before its first update. While the block is idle, the user writes
// registers via cfg_valid/cfg_ready/cfg_index/cfg_data; the block does not enforce it.
// While the output register holds a result and out_stall is high, the whole
// pipeline freezes and in_stall is raised in the same cycle.
// ----------------------------------------------------------------------------
module sigma_delta_background_subtract_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sdbs_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sdbs_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdbs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import sdbs_pkg::*;

  logic [AMP_W-1:0] amp_factor_r;
  logic [PIX_W-1:0] variance_min_r;
  logic [PIX_W-1:0] variance_max_r;

  logic             adv;
  s1_t              s1_r;
  s2_t              s2;
  s3_t              s3;
  logic [PIX_W-1:0] rd_mean;
  logic [PIX_W-1:0] rd_var;
  wr_rec_t          fwd_a;
  wr_rec_t          fwd_b;
  wr_rec_t          fwd_c;
  logic             wr_en;

  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             out_we_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [PIX_W-1:0] out_mean_r;
  logic [PIX_W-1:0] out_var_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_factor_r   <= AMP_FACTOR_RST;
      variance_min_r <= VARIANCE_MIN_RST;
      variance_max_r <= VARIANCE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AMP_FACTOR:   amp_factor_r   <= cfg_data[AMP_W-1:0];
        REG_VARIANCE_MIN: variance_min_r <= cfg_data;
        REG_VARIANCE_MAX: variance_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Every stage moves together unless a result is waiting on the receiver.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid <= in_valid;
      s1_r.we    <= (32'(in_data.pixel_index) < PIXELS);
      s1_r.func  <= in_data.func;
      s1_r.idx   <= in_data.pixel_index;
      s1_r.pix   <= in_data.pixel_value;
    end
  end

  assign wr_en = adv && s3.valid && s3.we;

  sdbs_store u_store (
    .clk     (clk),
    .adv     (adv),
    .rd_idx  (in_data.pixel_index),
    .rd_mean (rd_mean),
    .rd_var  (rd_var),
    .wr_en   (wr_en),
    .wr_idx  (s3.idx),
    .wr_mean (s3.mean),
    .wr_var  (s3.var_val)
  );

  // Writes the memory read of the item in stage one did not see, youngest
  // first: stage two, stage three, and the one committed at that read.
  always_comb begin
    fwd_c.we      = s2.valid && s2.we;
    fwd_c.idx     = s2.idx;
    fwd_c.mean    = s2.mean;
    fwd_c.var_val = s2.var_old;
    fwd_b.we      = s3.valid && s3.we;
    fwd_b.idx     = s3.idx;
    fwd_b.mean    = s3.mean;
    fwd_b.var_val = s3.var_val;
    fwd_a.we      = out_we_r;
    fwd_a.idx     = out_idx_r;
    fwd_a.mean    = out_mean_r;
    fwd_a.var_val = out_var_r;
  end

  sdbs_mean_stage u_mean_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1_i    (s1_r),
    .rd_mean (rd_mean),
    .rd_var  (rd_var),
    .fwd_c   (fwd_c),
    .fwd_b   (fwd_b),
    .fwd_a   (fwd_a),
    .s2_o    (s2)
  );

  sdbs_var_stage u_var_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .s2_i         (s2),
    .fwd_d        (fwd_b),
    .amp_factor   (amp_factor_r),
    .variance_min (variance_min_r),
    .variance_max (variance_max_r),
    .s3_o         (s3)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_we_r    <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3.valid;
      out_we_r    <= s3.valid && s3.we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.motion         <= s3.we && (s3.func == FUNC_UPDATE) &&
                                   (s3.diff >= s3.var_val);
      out_data_r.abs_difference <= s3.diff;
      out_idx_r                 <= s3.idx;
      out_mean_r                <= s3.mean;
      out_var_r                 <= s3.var_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_freeze_holds_s3: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && s3.valid) |=> $stable(s3))
    else $error("stage three changed while the output was stalled");

  a_init_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3.valid && (s3.func == FUNC_INIT)) |=> (out_data_r == '0))
    else $error("init request produced a nonzero result");

  a_bubble_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s3.valid) |=> (!out_valid_r && !out_we_r))
    else $error("empty stage produced a result or a store write");

  a_write_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s3.valid && !(out_valid_r && out_stall)))
    else $error("store written without a request moving out");
`endif

endmodule
